[rtl/bshd_pkg.sv]
// ----------------------------------------------------------------------------
// bshd_pkg
// Shared types and fixed widths for the batch scheduling hull DP block.
// ----------------------------------------------------------------------------
package bshd_pkg;

  localparam int TIME_W   = 12;
  localparam int WEIGHT_W = 12;
  localparam int SETUP_W  = 12;
  localparam int COST_W   = 64;
  localparam int MINC_W   = 51;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RDP,
    ST_RDI,
    ST_CAPI,
    ST_POPCHK,
    ST_HQ1,
    ST_HQ2,
    ST_JA,
    ST_JB,
    ST_MS,
    ST_MW,
    ST_CMP,
    ST_PUSH,
    ST_SRCHK,
    ST_J1,
    ST_J2,
    ST_UPD,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    SEL_LEFT,
    SEL_RIGHT,
    SEL_TIME,
    SEL_SETUP
  } mul_sel_t;

endpackage

[rtl/bshd_mul.sv]
// ----------------------------------------------------------------------------
// bshd_mul
// Shared signed shift-add multiplier, one bit of y per cycle.
// ----------------------------------------------------------------------------
module bshd_mul #(
  parameter int XW = 64,
  parameter int YW = 25
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [XW-1:0]        x,
  input  logic signed [YW-1:0]        y,
  output logic                        done,
  output logic signed [XW+YW-1:0]     prod
);
  import bshd_pkg::*;

  localparam int CNTW = $clog2(YW + 1);

  logic signed [XW+1:0] hi_r, hi_nxt;
  logic [YW-1:0]        lo_r, lo_nxt;
  logic signed [XW-1:0] x_r;
  logic [CNTW-1:0]      cnt_r;
  logic                 busy_r, done_r;
  logic signed [XW+1:0] xe, addend, sum;
  logic                 last;

  assign xe     = {{2{x_r[XW-1]}}, x_r};
  assign last   = (cnt_r == CNTW'(YW - 1));
  // sign bit of y carries negative weight
  assign addend = lo_r[0] ? (last ? -xe : xe) : '0;
  assign sum    = hi_r + addend;
  assign hi_nxt = {sum[XW+1], sum[XW+1:1]};
  assign lo_nxt = {sum[0], lo_r[YW-1:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi_r <= '0;
      lo_r <= y;
      x_r  <= x;
    end else if (busy_r) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign done = done_r;
  assign prod = {hi_r[XW-1:0], lo_r};

endmodule

[rtl/batch_schedule_hull_dp.sv]
// ----------------------------------------------------------------------------
// batch_schedule_hull_dp
// Batch scheduling DP with a convex hull queue and binary predecessor search.
// ----------------------------------------------------------------------------
// Jobs load at one word per cycle; each stores running time and weight
// prefixes. The word with in_tlast starts the DP over the stored jobs, and
// input stalls until it is done. Every DP step reads prefixes, costs and hull
// entries one at a time through memories with one read port each, and runs
// all products through one shift-add multiplier that steps NY = 13 +
// clog2(MAX_JOBS+2) times. A step takes two products for its cost, and each
// slope test takes two more: one test per pop or kept hull entry and one per
// binary search probe. One result word carries the minimum cost and a flag
// for jobs dropped past MAX_JOBS; it is held in its own register, so the next
// frame may load and run while it waits, and that frame stalls only when its
// own result is ready.
module batch_schedule_hull_dp #(
  parameter int MAX_JOBS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // job_time[11:0], job_weight[23:12]
  input  logic        in_tlast,   // last_job
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // min_cost[50:0], zero pad
  output logic [0:0]  out_tuser,  // overflow
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data    // setup_time
);
  import bshd_pkg::*;

  localparam int IW    = $clog2(MAX_JOBS + 2);
  localparam int PW    = TIME_W + IW;
  localparam int NY    = PW + 1;
  localparam int PRW   = COST_W + NY;
  localparam int DEPTH = MAX_JOBS + 1;
  localparam logic [IW-1:0] MAX_CNT = IW'(MAX_JOBS);
  localparam logic [IW-1:0] HEAD    = IW'(1);

  state_t   state_r, state_nxt;
  mul_sel_t msel_r;

  logic [SETUP_W-1:0] setup_r;
  logic [IW-1:0] cnt_r, n_r, i_r, tail_r, l_r, r_r, m_r, pos2_r, a_r, b_r;
  logic signed [PW-1:0] tsum_r, ti_r;
  logic [PW-1:0] wsum_r, wn_r, wp_r, wa_r, wb_r, wj_r, wi_r;
  logic signed [COST_W-1:0] bcp_r, bca_r, bcb_r, bcj_r, pa_r, cost_nxt;
  logic signed [PRW-1:0] prod1_r;
  logic sticky_r, srch_r;
  logic out_valid_r, out_ovf_r;
  logic [MINC_W-1:0] out_cost_r, fin_cost_r;

  // memories
  logic signed [PW-1:0]     tp_mem [DEPTH];
  logic [PW-1:0]            wp_mem [DEPTH];
  logic signed [COST_W-1:0] bc_mem [DEPTH];
  logic [IW-1:0]            hq_mem [DEPTH];
  logic [IW-1:0] job_ra, hq_ra, hq_q;
  logic signed [PW-1:0] tp_q, tp_v;
  logic [PW-1:0] wp_q, wp_v;
  logic signed [COST_W-1:0] bc_q, bc_v;
  logic jz_r;

  // handshake
  logic acc, store, load_done;
  logic signed [TIME_W-1:0] job_t;
  logic [WEIGHT_W-1:0] job_w;
  logic signed [PW-1:0] tsum_new;
  logic [PW-1:0] wsum_new;

  // multiplier
  logic mul_start, mul_done;
  logic signed [COST_W-1:0] mx;
  logic signed [NY-1:0] my, ksum;
  logic signed [PRW-1:0] mprod;
  logic prod_le;
  logic [IW:0] lr_sum;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign store     = acc && (cnt_r != MAX_CNT);
  assign job_t     = in_tdata[11:0];
  assign job_w     = in_tdata[23:12];
  assign tsum_new  = tsum_r + {{(PW-TIME_W){job_t[TIME_W-1]}}, job_t};
  assign wsum_new  = wsum_r + {{(PW-WEIGHT_W){1'b0}}, job_w};
  assign load_done = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  // entry zero of every job store reads as zero
  assign tp_v = jz_r ? '0 : tp_q;
  assign wp_v = jz_r ? '0 : wp_q;
  assign bc_v = jz_r ? '0 : bc_q;

  always_ff @(posedge clk) begin
    if (store) begin
      tp_mem[cnt_r + 1'b1] <= tsum_new;
      wp_mem[cnt_r + 1'b1] <= wsum_new;
    end
    if (state_r == ST_UPD) bc_mem[i_r] <= cost_nxt;
    if (state_r == ST_PUSH) hq_mem[tail_r + 1'b1] <= i_r - 1'b1;
    tp_q <= tp_mem[job_ra];
    wp_q <= wp_mem[job_ra];
    bc_q <= bc_mem[job_ra];
    jz_r <= (job_ra == '0);
    hq_q <= hq_mem[hq_ra];
  end

  // operand select for the shared multiplier
  assign ksum = $signed({{(NY-SETUP_W){1'b0}}, setup_r}) + $signed({ti_r[PW-1], ti_r});

  always_comb begin
    mx = '0;
    my = '0;
    case (msel_r)
      SEL_LEFT: begin
        if (srch_r) begin
          mx = bca_r - bcb_r;
          my = NY'(1);
        end else begin
          mx = bcp_r - bca_r;
          my = $signed({1'b0, wa_r}) - $signed({1'b0, wb_r});
        end
      end
      SEL_RIGHT: begin
        if (srch_r) begin
          mx = {{(COST_W-NY){ksum[NY-1]}}, ksum};
          my = $signed({1'b0, wa_r}) - $signed({1'b0, wb_r});
        end else begin
          mx = bca_r - bcb_r;
          my = $signed({1'b0, wp_r}) - $signed({1'b0, wa_r});
        end
      end
      SEL_TIME: begin
        mx = {{(COST_W-PW){ti_r[PW-1]}}, ti_r};
        my = $signed({1'b0, wi_r}) - $signed({1'b0, wj_r});
      end
      default: begin
        mx = {{(COST_W-SETUP_W){1'b0}}, setup_r};
        my = $signed({1'b0, wn_r}) - $signed({1'b0, wj_r});
      end
    endcase
  end

  bshd_mul #(.XW(COST_W), .YW(NY)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (mx),
    .y     (my),
    .done  (mul_done),
    .prod  (mprod)
  );

  assign prod_le  = (prod1_r <= mprod);
  assign cost_nxt = bcj_r + pa_r + mprod[COST_W-1:0];
  assign lr_sum   = {1'b0, l_r} + {1'b0, r_r};

  // sequencer: next state and memory addresses
  always_comb begin
    state_nxt = state_r;
    job_ra    = '0;
    hq_ra     = '0;
    mul_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && in_tlast) state_nxt = ST_RDP;
      end
      ST_RDP: begin
        job_ra    = i_r - 1'b1;
        state_nxt = ST_RDI;
      end
      ST_RDI: begin
        job_ra    = i_r;
        state_nxt = ST_CAPI;
      end
      ST_CAPI: state_nxt = ST_POPCHK;
      ST_POPCHK: begin
        hq_ra     = tail_r;
        state_nxt = (HEAD < tail_r) ? ST_HQ1 : ST_PUSH;
      end
      ST_HQ1: begin
        hq_ra     = pos2_r;
        state_nxt = ST_HQ2;
      end
      ST_HQ2: begin
        job_ra    = a_r;
        state_nxt = ST_JA;
      end
      ST_JA: begin
        job_ra    = b_r;
        state_nxt = ST_JB;
      end
      ST_JB: state_nxt = ST_MS;
      ST_MS: begin
        mul_start = 1'b1;
        state_nxt = ST_MW;
      end
      ST_MW: begin
        if (mul_done) begin
          if (msel_r == SEL_RIGHT) state_nxt = ST_CMP;
          else if (msel_r == SEL_SETUP) state_nxt = ST_UPD;
          else state_nxt = ST_MS;
        end
      end
      ST_CMP: begin
        if (srch_r) state_nxt = ST_SRCHK;
        else state_nxt = prod_le ? ST_POPCHK : ST_PUSH;
      end
      ST_PUSH: state_nxt = ST_SRCHK;
      ST_SRCHK: begin
        if ({1'b0, l_r} + 1'b1 < {1'b0, r_r}) begin
          hq_ra     = lr_sum[IW:1];
          state_nxt = ST_HQ1;
        end else begin
          hq_ra     = l_r;
          state_nxt = ST_J1;
        end
      end
      ST_J1: begin
        job_ra    = hq_q;
        state_nxt = ST_J2;
      end
      ST_J2: state_nxt = ST_MS;
      ST_UPD: state_nxt = (i_r == n_r) ? ST_FIN : ST_RDP;
      ST_FIN: begin
        if (load_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_r     <= '0;
      cnt_r       <= '0;
      tsum_r      <= '0;
      wsum_r      <= '0;
      sticky_r    <= 1'b0;
      i_r         <= '0;
      n_r         <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) setup_r <= cfg_data;
      if (out_valid_r && out_tready && !load_done) out_valid_r <= 1'b0;
      if (store) begin
        cnt_r  <= cnt_r + 1'b1;
        tsum_r <= tsum_new;
        wsum_r <= wsum_new;
      end
      if (acc && !store) sticky_r <= 1'b1;
      if (acc && in_tlast) begin
        n_r    <= store ? cnt_r + 1'b1 : cnt_r;
        i_r    <= IW'(1);
        tail_r <= '0;
      end
      if (state_r == ST_CMP && !srch_r && prod_le) tail_r <= tail_r - 1'b1;
      if (state_r == ST_PUSH) tail_r <= tail_r + 1'b1;
      if (state_r == ST_UPD && i_r != n_r) i_r <= i_r + 1'b1;
      if (load_done) begin
        // start a new problem, keep setup
        out_valid_r <= 1'b1;
        cnt_r       <= '0;
        tsum_r      <= '0;
        wsum_r      <= '0;
        sticky_r    <= 1'b0;
        tail_r      <= '0;
        i_r         <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (acc && in_tlast) wn_r <= store ? wsum_new : wsum_r;
    if (state_r == ST_RDI) begin
      bcp_r <= bc_v;
      wp_r  <= wp_v;
    end
    if (state_r == ST_CAPI) begin
      ti_r <= tp_v;
      wi_r <= wp_v;
    end
    if (state_r == ST_POPCHK) begin
      pos2_r <= tail_r - 1'b1;
      srch_r <= 1'b0;
    end
    if (state_r == ST_HQ1) a_r <= hq_q;
    if (state_r == ST_HQ2) b_r <= hq_q;
    if (state_r == ST_JA) begin
      bca_r <= bc_v;
      wa_r  <= wp_v;
    end
    if (state_r == ST_JB) begin
      bcb_r  <= bc_v;
      wb_r   <= wp_v;
      msel_r <= SEL_LEFT;
    end
    if (state_r == ST_MW && mul_done) begin
      if (msel_r == SEL_LEFT) begin
        prod1_r <= mprod;
        msel_r  <= SEL_RIGHT;
      end
      if (msel_r == SEL_TIME) begin
        pa_r   <= mprod[COST_W-1:0];
        msel_r <= SEL_SETUP;
      end
    end
    if (state_r == ST_CMP && srch_r) begin
      if (prod_le) l_r <= m_r;
      else r_r <= m_r;
    end
    if (state_r == ST_PUSH) begin
      l_r <= HEAD;
      r_r <= tail_r + IW'(2);
    end
    if (state_r == ST_SRCHK) begin
      m_r    <= lr_sum[IW:1];
      pos2_r <= lr_sum[IW:1] - 1'b1;
      srch_r <= 1'b1;
    end
    if (state_r == ST_J2) begin
      bcj_r  <= bc_v;
      wj_r   <= wp_v;
      msel_r <= SEL_TIME;
    end
    // hold the running cost apart from a result word that may still wait
    if (state_r == ST_UPD) fin_cost_r <= cost_nxt[MINC_W-1:0];
    if (load_done) begin
      out_cost_r <= fin_cost_r;
      out_ovf_r  <= sticky_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(56-MINC_W){1'b0}}, out_cost_r};
  assign out_tuser  = out_ovf_r;

  // the hull never holds more entries than the states computed so far
  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= i_r) else $error("hull tail past current step");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (i_r <= n_r && i_r != '0))
    else $error("DP step out of range");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> (state_r == ST_RDP))
    else $error("last job did not start the DP");

endmodule
